### sv/packet_coherent_averager_core_assert.svh
// ----------------------------------------------------------------------------
// packet_coherent_averager_core_assert.svh
// assertion macros used by the checker file pca_checker
// ----------------------------------------------------------------------------
`ifndef PACKET_COHERENT_AVERAGER_CORE_ASSERT_SVH
`define PACKET_COHERENT_AVERAGER_CORE_ASSERT_SVH

// property checked at every clock edge outside reset
`define PCA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define PCA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// types, widths and helpers of the coherent block averager
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  localparam int MAX_BLOCK  = 1024;
  localparam int ADDR_W     = $clog2(MAX_BLOCK);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 40;
  localparam int LEN_W      = 11;
  localparam int AVG_W      = 8;
  localparam int FRAG_LEN   = 260;
  localparam int FRAG_W     = $clog2(FRAG_LEN);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 11;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_BLOCK);
  localparam logic [AVG_W-1:0] AVG_RESET = AVG_W'(1);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH      = 1'b0,
    REG_BLOCKS_TO_AVERAGE = 1'b1
  } reg_idx_t;

  // position inside an averaging round
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_REST
  } phase_t;

  // control sequencer of the core
  typedef enum logic [1:0] {
    ST_WAIT,
    ST_ADD,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v < LEN_W'(2)) begin
      r = LEN_W'(2);
    end else if (v > LEN_W'(MAX_BLOCK)) begin
      r = LEN_W'(MAX_BLOCK);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/pca_if.sv
// ----------------------------------------------------------------------------
// pca_if
// valid/ready channels for samples in and averages out
// ----------------------------------------------------------------------------
`default_nettype none

interface pca_sample_if
  import pca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pca_result_if
  import pca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic                last;

  modport source (output valid, output average, output last, input ready);
  modport sink   (input valid, input average, input last, output ready);
endinterface

`default_nettype wire

### sv/packet_coherent_averager_core.sv
// ----------------------------------------------------------------------------
// packet_coherent_averager_core
// element-wise average of consecutive sample blocks
// ----------------------------------------------------------------------------
// samples enter on a valid/ready channel, averages leave on another, each
// result with a last flag at the end of a sequence or of a 260-item fragment.
// block_length and blocks_to_average are taken when a new averaging round
// starts; 0 or 1 blocks to average passes every item through.
// the per-position sums sit in one 1024 x 40 ram (read, add, write back).
// steps per item:
//   first block of a round: raw sample written to the ram, no result
//   middle blocks: ram read, then add and write back, no result
//   pass-through: sample goes straight to the registered output
//   final block: ram read and add, then the 40-step serial divider
// one item is in work at a time; an accepted item whose result cannot leave
// waits in the core while the output register holds the previous result.
// a stalled receiver holds the output register and, behind it, the input.
// reset clears the control state and restores the register defaults; the
// sum ram needs no clearing, each entry is written in the first block.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_coherent_averager_core
  import pca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  pca_sample_if.sink                samples,
  pca_result_if.source              results
);

  // configuration and latched round settings
  logic [LEN_W-1:0]    block_length;
  logic [AVG_W-1:0]    blocks_to_average;
  logic [LEN_W-1:0]    len_lat;
  logic [AVG_W-1:0]    avg_lat;

  // round state
  phase_t              phase;
  logic [ADDR_W-1:0]   sample_index;
  logic [AVG_W-1:0]    block_index;
  logic [ADDR_W-1:0]   out_pos;
  logic [FRAG_W-1:0]   frag_cnt;

  // sequencer
  state_t              state, state_next;
  logic [ADDR_W-1:0]   pos_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                mid_q;
  logic [SAMPLE_W-1:0] result_q;

  // accept-cycle decode
  logic                accept;
  logic [LEN_W-1:0]    eff_len;
  logic [AVG_W-1:0]    eff_avg;
  logic [ADDR_W-1:0]   idx;
  logic                pass;
  logic                end_blk;
  logic                mid;

  // memory and divider
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SUM_W-1:0]    ram_wdata;
  logic [SUM_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]    sum;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_q;

  logic                emit_go;
  logic                end_seq;

  assign accept  = samples.valid && samples.ready;
  assign eff_len = (phase == PH_IDLE) ? clamp_len(block_length) : len_lat;
  assign eff_avg = (phase == PH_IDLE) ? blocks_to_average : avg_lat;
  assign idx     = (phase == PH_IDLE) ? '0 : sample_index;
  assign pass    = eff_avg <= AVG_W'(1);
  assign end_blk = {1'b0, idx} == eff_len - LEN_W'(1);
  assign mid     = ({1'b0, block_index} + (AVG_W+1)'(1)) < {1'b0, eff_avg};
  assign sum     = ram_rdata + {(SUM_W-SAMPLE_W)'(0), sample_q};
  assign end_seq = {1'b0, out_pos} == len_lat - LEN_W'(1);

  pca_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_BLOCK)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  pca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (avg_lat),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WAIT: begin
        if (accept) begin
          if (phase == PH_REST) begin
            state_next = ST_ADD;
          end else if (pass) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_ADD: begin
        if (mid_q) begin
          state_next = ST_WAIT;
        end else if (avg_lat == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_WAIT;
        end
      end
      default: state_next = ST_WAIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    samples.ready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = {(SUM_W-SAMPLE_W)'(0), samples.sample};
    div_start     = 1'b0;
    emit_go       = 1'b0;
    unique case (state)
      ST_WAIT: begin
        samples.ready = 1'b1;
        // first block of a round stores the raw sample
        ram_we = samples.valid && !pass && phase != PH_REST;
      end
      ST_ADD: begin
        ram_we    = mid_q;
        ram_waddr = pos_q;
        ram_wdata = sum;
        div_start = !mid_q && avg_lat != '0;
      end
      ST_DIV: begin
      end
      ST_EMIT: begin
        emit_go = !results.valid || results.ready;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length      <= LEN_RESET;
      blocks_to_average <= AVG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:      block_length      <= cfg_data[LEN_W-1:0];
        REG_BLOCKS_TO_AVERAGE: blocks_to_average <= cfg_data[AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state and round bookkeeping, the latter updated when an item is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_WAIT;
      phase        <= PH_IDLE;
      sample_index <= '0;
      block_index  <= '0;
      len_lat      <= LEN_RESET;
      avg_lat      <= AVG_RESET;
    end else begin
      state <= state_next;
      if (accept) begin
        if (phase == PH_IDLE) begin
          len_lat <= eff_len;
          avg_lat <= eff_avg;
        end
        if (phase != PH_REST) begin
          if (phase == PH_FIRST && end_blk) begin
            sample_index <= '0;
            phase        <= pass ? PH_IDLE : PH_REST;
            block_index  <= pass ? '0 : AVG_W'(1);
          end else begin
            sample_index <= idx + ADDR_W'(1);
            phase        <= PH_FIRST;
          end
        end else if (end_blk) begin
          sample_index <= '0;
          if (mid) begin
            block_index <= block_index + AVG_W'(1);
          end else begin
            block_index <= '0;
            phase       <= PH_IDLE;
          end
        end else begin
          sample_index <= idx + ADDR_W'(1);
        end
      end
    end
  end

  // item payload held through the read-modify-write, and the result to emit
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q    <= idx;
      sample_q <= samples.sample;
      mid_q    <= mid;
      result_q <= samples.sample;
    end else if (state == ST_ADD) begin
      result_q <= sum[SAMPLE_W-1:0];
    end else if (state == ST_DIV && div_done) begin
      result_q <= div_q;
    end
  end

  // output register and last flag tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      out_pos       <= '0;
      frag_cnt      <= '0;
    end else begin
      if (emit_go) begin
        results.valid <= 1'b1;
        if (frag_cnt == FRAG_W'(FRAG_LEN - 1) || end_seq) begin
          frag_cnt <= '0;
        end else begin
          frag_cnt <= frag_cnt + FRAG_W'(1);
        end
        out_pos <= end_seq ? '0 : out_pos + ADDR_W'(1);
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      results.average <= result_q;
      results.last    <= frag_cnt == FRAG_W'(FRAG_LEN - 1) || end_seq;
    end
  end

endmodule

`default_nettype wire

### sv/pca_ram.sv
// ----------------------------------------------------------------------------
// pca_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pca_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/pca_div.sv
// ----------------------------------------------------------------------------
// pca_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pca_div
  import pca_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SUM_W-1:0]    dividend,
  input  wire logic [AVG_W-1:0]    divisor,
  output logic                     done,
  output logic      [SAMPLE_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     work;
  logic [AVG_W-1:0]     dvs;
  logic [AVG_W-1:0]     rem;
  logic [AVG_W:0]       trial;
  logic                 fits;

  assign trial    = {rem, work[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = work[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      cnt  <= DIV_CNT_W'(SUM_W - 1);
    end else if (busy) begin
      // quotient bits shift in where dividend bits shift out
      if (fits) begin
        rem  <= AVG_W'(trial - {1'b0, dvs});
        work <= {work[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[AVG_W-1:0];
        work <= {work[SUM_W-2:0], 1'b0};
      end
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### sv/pca_checker.sv
// ----------------------------------------------------------------------------
// pca_checker
// port-level checks of the averager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_coherent_averager_core_assert.svh"

module pca_checker
  import pca_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_average,
  input wire logic                out_last
);

  logic in_accept;

  assign in_accept = in_valid && in_ready;

  // a result waiting on the receiver stays
  `PCA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `PCA_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable({out_average, out_last}), "stalled result changed")
  // reset empties the output register
  `PCA_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid, "result valid after reset")
  // a result needs an item accepted after reset, so never right behind it
  `PCA_ASSERT(a_no_early_result, clk, rst, $rose(out_valid) |-> !$past(rst) && !$past(rst, 2) && !$past(in_accept), "result without item")

endmodule

bind packet_coherent_averager_core pca_checker u_pca_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_average (results.average),
  .out_last    (results.last)
);

`default_nettype wire
